// ===== design/ctst_pkg.sv =====
// shared widths, constants and bundle types of the specular term pipeline
`timescale 1ns / 1ps
`default_nettype none
package ctst_pkg;

  localparam int unsigned NUM_W  = 48;  // distribution numerator and quotient
  localparam int unsigned DD_W   = 37;  // squared ggx denominator
  localparam int unsigned VEC_W  = 20;  // clamped cosines nl and nv, q.16
  localparam int unsigned GD_W   = 21;  // geometry denominator magnitude
  localparam int unsigned GQ_W   = 36;  // geometry factor magnitude
  localparam int unsigned DEN_W  = 43;  // 4*nl*nv + eps, q.32
  localparam int unsigned MAG_W  = 63;  // saturated product magnitude
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned GN_PAD = NUM_W - VEC_W - 16;

  localparam logic [14:0]      INV_PI_Q16 = 15'd20861;
  localparam logic [DEN_W-1:0] EPS_Q32    = 43'd42950;
  localparam logic [MAG_W-1:0] MAG_LIMIT  = 63'h1 << 62;

  typedef struct packed {
    logic [NUM_W-1:0] dq_num;
    logic [DD_W-1:0]  dd;
    logic             dd_zero;
    logic [VEC_W-1:0] nl;
    logic [VEC_W-1:0] nv;
    logic [GD_W-1:0]  g1_den;
    logic             g1_neg;
    logic             g1_zero;
    logic [GD_W-1:0]  g2_den;
    logic             g2_neg;
    logic             g2_zero;
    logic [DEN_W-1:0] den;
  } front_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic             dd_zero;
  } dq_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] dq;
    logic [DEN_W-1:0] den;
    logic             dd_zero;
    logic             neg;
  } g_side_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic             dd_zero;
    logic             neg;
  } dg_side_t;

endpackage
`default_nettype wire

// ===== design/ctst_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ctst_div #(
  parameter int unsigned D_W    = 43,
  parameter int unsigned Q_W    = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [D_W-1:0]    rem_init,
  input  wire logic [Q_W-1:0]    num,
  input  wire logic [D_W-1:0]    den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [Q_W-1:0]         quo,
  output logic [SIDE_W-1:0]      side_out
);

  logic [Q_W-1:0]    v_r;
  logic [D_W-1:0]    rem_r    [Q_W];
  logic [Q_W-1:0]    num_r    [Q_W];
  logic [Q_W-1:0]    quo_r    [Q_W];
  logic [D_W-1:0]    den_r    [Q_W];
  logic [SIDE_W-1:0] side_r   [Q_W];
  logic [D_W-1:0]    rem_cur  [Q_W];
  logic [Q_W-1:0]    num_cur  [Q_W];
  logic [Q_W-1:0]    quo_cur  [Q_W];
  logic [D_W-1:0]    den_cur  [Q_W];
  logic [SIDE_W-1:0] side_cur [Q_W];
  logic [D_W-1:0]    rem_nxt  [Q_W];
  logic [Q_W-1:0]    num_nxt  [Q_W];
  logic [Q_W-1:0]    quo_nxt  [Q_W];

  always_comb begin
    logic [D_W:0] trial;
    logic         ge;
    rem_cur[0]  = rem_init;
    num_cur[0]  = num;
    quo_cur[0]  = '0;
    den_cur[0]  = den;
    side_cur[0] = side_in;
    for (int s = 1; s < Q_W; s++) begin
      rem_cur[s]  = rem_r[s-1];
      num_cur[s]  = num_r[s-1];
      quo_cur[s]  = quo_r[s-1];
      den_cur[s]  = den_r[s-1];
      side_cur[s] = side_r[s-1];
    end
    for (int s = 0; s < Q_W; s++) begin
      // bring down the next numerator bit, subtract when it fits
      trial      = {rem_cur[s], num_cur[s][Q_W-1]};
      ge         = trial >= {1'b0, den_cur[s]};
      rem_nxt[s] = ge ? D_W'(trial - {1'b0, den_cur[s]}) : trial[D_W-1:0];
      quo_nxt[s] = {quo_cur[s][Q_W-2:0], ge};
      num_nxt[s] = num_cur[s] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Q_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      quo_r  <= quo_nxt;
      den_r  <= den_cur;
      side_r <= side_cur;
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign quo       = quo_r[Q_W-1];
  assign side_out  = side_r[Q_W-1];

endmodule
`default_nettype wire

// ===== design/ctst_mulsat.sv =====
// three stage q.16 magnitude multiplier, clamped at 2^62
`timescale 1ns / 1ps
`default_nettype none
module ctst_mulsat #(
  parameter int unsigned A_W    = 48,
  parameter int unsigned B_W    = 63,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [A_W-1:0]               a,
  input  wire logic [B_W-1:0]               b,
  input  wire logic [SIDE_W-1:0]            side_in,
  output logic                              out_valid,
  output logic [ctst_pkg::MAG_W-1:0]        mag,
  output logic [SIDE_W-1:0]                 side_out
);

  localparam int unsigned HH_W  = A_W + B_W - 64;
  localparam int unsigned MID_W = ((A_W > B_W) ? A_W : B_W) + 1;
  localparam logic [64:0] PROD_LIMIT = 65'h1 << 62;

  logic [2:0]          v_r;
  logic [63:0]         p_ll_r;
  logic [B_W-1:0]      p_lh_r;
  logic [A_W-1:0]      p_hl_r;
  logic [HH_W-1:0]     p_hh_r;
  logic [SIDE_W-1:0]   side1_r;
  logic [MID_W-1:0]    mid_r;
  logic                hh_nz_r;
  logic [63:0]         p_ll2_r;
  logic [SIDE_W-1:0]   side2_r;
  logic [64:0]         sum;
  logic                sat;
  logic [ctst_pkg::MAG_W-1:0] mag_nxt;
  logic [ctst_pkg::MAG_W-1:0] mag_r;
  logic [SIDE_W-1:0]   side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  // partial products on 32 bit halves
  always_ff @(posedge clk) begin
    if (en) begin
      p_ll_r  <= a[31:0] * b[31:0];
      p_lh_r  <= a[31:0] * b[B_W-1:32];
      p_hl_r  <= a[A_W-1:32] * b[31:0];
      p_hh_r  <= a[A_W-1:32] * b[B_W-1:32];
      side1_r <= side_in;
      mid_r   <= MID_W'(p_lh_r) + MID_W'(p_hl_r);
      hh_nz_r <= |p_hh_r;
      p_ll2_r <= p_ll_r;
      side2_r <= side1_r;
      mag_r   <= mag_nxt;
      side3_r <= side2_r;
    end
  end

  always_comb begin
    sum = {2'b00, mid_r[30:0], 32'd0} + {1'b0, p_ll2_r};
    sat = hh_nz_r || (|mid_r[MID_W-1:31]) || (sum > PROD_LIMIT);
    mag_nxt = sat ? ctst_pkg::MAG_LIMIT : {16'd0, sum[62:16]};
  end

  assign out_valid = v_r[2];
  assign mag       = mag_r;
  assign side_out  = side3_r;

endmodule
`default_nettype wire

// ===== design/ctst_front.sv =====
// front stages: dot products, ggx denominator, geometry denominators, eps term
`timescale 1ns / 1ps
`default_nettype none
module ctst_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] incoming_x,
  input  wire logic signed [15:0] incoming_y,
  input  wire logic signed [15:0] incoming_z,
  input  wire logic signed [15:0] outgoing_x,
  input  wire logic signed [15:0] outgoing_y,
  input  wire logic signed [15:0] outgoing_z,
  input  wire logic signed [15:0] normal_x,
  input  wire logic signed [15:0] normal_y,
  input  wire logic signed [15:0] normal_z,
  input  wire logic [14:0]        half_cosine,
  input  wire logic [14:0]        roughness_squared,
  output logic                    out_valid,
  output ctst_pkg::front_t        res
);

  logic [5:0] v_r;

  logic [16:0]        nh;
  logic [16:0]        a_in;
  logic signed [31:0] pl0_r, pl1_r, pl2_r, pv0_r, pv1_r, pv2_r;
  logic [33:0]        nhsq_r;
  logic [31:0]        aop1_r;
  logic [16:0]        a1_r;

  logic signed [33:0] dotl_r, dotv_r;
  logic [17:0]        nh2_r;
  logic [31:0]        aop2_r;
  logic [16:0]        a2_r;

  logic signed [17:0] am1;
  logic [ctst_pkg::VEC_W-1:0] nl3_r, nv3_r;
  logic signed [36:0] tprod_r;
  logic [31:0]        aop3_r;
  logic [16:0]        a3_r;

  logic signed [36:0] tadj;
  logic signed [17:0] omk;
  logic signed [20:0] denom_r;
  logic signed [38:0] pd1_r, pd2_r;
  logic [39:0]        nlnv_r;
  logic [ctst_pkg::VEC_W-1:0] nl4_r, nv4_r;
  logic [31:0]        aop4_r;
  logic [16:0]        a4_r;

  logic signed [41:0] ddsq;
  logic signed [38:0] p1adj, p2adj;
  logic [ctst_pkg::DD_W-1:0]  dd5_r;
  logic                       ddz5_r;
  logic signed [22:0]         gd1_r, gd2_r;
  logic [ctst_pkg::DEN_W-1:0] den5_r;
  logic [ctst_pkg::NUM_W-1:0] dqnum5_r;
  logic [ctst_pkg::VEC_W-1:0] nl5_r, nv5_r;

  ctst_pkg::front_t res_r;

  assign nh   = {half_cosine, 2'b00};
  assign a_in = {roughness_squared, 2'b00};
  assign am1  = $signed({1'b0, a2_r}) - 18'sd65536;
  // truncate toward zero on the divide by 2^16
  assign tadj = tprod_r + (tprod_r[36] ? 37'sd65535 : 37'sd0);
  assign omk  = 18'sd65536 - $signed({1'b0, a3_r});
  assign ddsq = denom_r * denom_r;
  assign p1adj = pd1_r + (pd1_r[38] ? 39'sd65535 : 39'sd0);
  assign p2adj = pd2_r + (pd2_r[38] ? 39'sd65535 : 39'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      pl0_r  <= normal_x * outgoing_x;
      pl1_r  <= normal_y * outgoing_y;
      pl2_r  <= normal_z * outgoing_z;
      pv0_r  <= normal_x * incoming_x;
      pv1_r  <= normal_y * incoming_y;
      pv2_r  <= normal_z * incoming_z;
      nhsq_r <= nh * nh;
      aop1_r <= a_in * ctst_pkg::INV_PI_Q16;
      a1_r   <= a_in;
      // stage 2
      dotl_r <= 34'(pl0_r) + 34'(pl1_r) + 34'(pl2_r);
      dotv_r <= -(34'(pv0_r) + 34'(pv1_r) + 34'(pv2_r));
      nh2_r  <= nhsq_r[33:16];
      aop2_r <= aop1_r;
      a2_r   <= a1_r;
      // stage 3
      nl3_r   <= (dotl_r > 34'sd0) ? dotl_r[31:12] : '0;
      nv3_r   <= (dotv_r > 34'sd0) ? dotv_r[31:12] : '0;
      tprod_r <= $signed({1'b0, nh2_r}) * am1;
      aop3_r  <= aop2_r;
      a3_r    <= a2_r;
      // stage 4
      denom_r <= 21'(tadj >>> 16) + 21'sd65536;
      pd1_r   <= $signed({1'b0, nl3_r}) * omk;
      pd2_r   <= $signed({1'b0, nv3_r}) * omk;
      nlnv_r  <= nl3_r * nv3_r;
      nl4_r   <= nl3_r;
      nv4_r   <= nv3_r;
      aop4_r  <= aop3_r;
      a4_r    <= a3_r;
      // stage 5
      dd5_r    <= ddsq[36:0];
      ddz5_r   <= denom_r == 21'sd0;
      gd1_r    <= 23'(p1adj >>> 16) + 23'($signed({1'b0, a4_r}));
      gd2_r    <= 23'(p2adj >>> 16) + 23'($signed({1'b0, a4_r}));
      den5_r   <= 43'({nlnv_r, 2'b00}) + ctst_pkg::EPS_Q32;
      dqnum5_r <= {aop4_r, 16'd0};
      nl5_r    <= nl4_r;
      nv5_r    <= nv4_r;
      // stage 6, sign and magnitude of the geometry denominators
      res_r.dq_num  <= dqnum5_r;
      res_r.dd      <= dd5_r;
      res_r.dd_zero <= ddz5_r;
      res_r.nl      <= nl5_r;
      res_r.nv      <= nv5_r;
      res_r.g1_den  <= gd1_r[22] ? 21'(-gd1_r) : 21'(gd1_r);
      res_r.g1_neg  <= gd1_r[22];
      res_r.g1_zero <= gd1_r == 23'sd0;
      res_r.g2_den  <= gd2_r[22] ? 21'(-gd2_r) : 21'(gd2_r);
      res_r.g2_neg  <= gd2_r[22];
      res_r.g2_zero <= gd2_r == 23'sd0;
      res_r.den     <= den5_r;
    end
  end

  assign out_valid = v_r[5];
  assign res       = res_r;

endmodule
`default_nettype wire

// ===== design/cook_torrance_specular_term.sv =====
// top level of the ggx cook-torrance specular term pipeline
// Usage:
//   Input channel in_valid/in_ready carries three signed q2.14 vectors
//   (incoming, outgoing, normal), the half vector cosine and the squared
//   roughness. Output channel out_valid/out_ready carries the q16.16
//   specular value and a saturation flag, one result per input, in order.
//   Items pass through six front stages, a 48 stage distribution divider
//   (geometry dividers run beside it), two 3 stage multipliers, a
//   classify stage, a 32 stage final divider and the output register.
//   Throughput is one item per cycle while in_ready is high. Items keep
//   entering while a result waits in the output register until one
//   reaches the last divider stage; then in_ready drops and the whole
//   pipeline holds, so nothing is lost or repeated. Reset (rst_n low,
//   synchronous) clears all valid bits; no state survives between items.
`timescale 1ns / 1ps
`default_nettype none
module cook_torrance_specular_term (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_incoming_x,
  input  wire logic signed [15:0] in_incoming_y,
  input  wire logic signed [15:0] in_incoming_z,
  input  wire logic signed [15:0] in_outgoing_x,
  input  wire logic signed [15:0] in_outgoing_y,
  input  wire logic signed [15:0] in_outgoing_z,
  input  wire logic signed [15:0] in_normal_x,
  input  wire logic signed [15:0] in_normal_y,
  input  wire logic signed [15:0] in_normal_z,
  input  wire logic [14:0]        in_half_cosine,
  input  wire logic [14:0]        in_roughness_squared,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_specular_value,
  output logic                    out_saturated
);

  typedef enum logic [1:0] {RES_DIV, RES_ZERO, RES_SAT} res_kind_t;

  logic adv;
  logic oload;

  logic              fr_valid;
  ctst_pkg::front_t  fr;

  ctst_pkg::dq_side_t dqs_in, dqs_out;
  logic               dq_valid, g1_valid, g2_valid;
  logic [ctst_pkg::NUM_W-1:0] dq_quo, g1_quo, g2_quo;
  logic [1:0]         g1_side_in, g1_side_out, g2_side_in, g2_side_out;
  logic [ctst_pkg::GQ_W-1:0]  g1_mag, g2_mag;

  ctst_pkg::g_side_t  gs_in, gs_out;
  logic               gm_valid;
  logic [ctst_pkg::MAG_W-1:0] gm_mag;

  ctst_pkg::dg_side_t dgs_in, dgs_out;
  logic               dgm_valid;
  logic [ctst_pkg::MAG_W-1:0] dg_mag;

  res_kind_t                  kind_nxt;
  logic                       cls_valid_r;
  res_kind_t                  cls_kind_r;
  logic [ctst_pkg::DEN_W-1:0] cls_x_r;
  logic [ctst_pkg::DEN_W-1:0] cls_den_r;

  logic                       fin_valid;
  logic [ctst_pkg::OUT_W-1:0] fin_quo;
  logic [1:0]                 fin_side;

  logic [ctst_pkg::OUT_W-1:0] value_nxt;
  logic                       sat_nxt;
  logic                       out_valid_r;
  logic [ctst_pkg::OUT_W-1:0] value_r;
  logic                       sat_r;

  // the pipe moves unless a finished item sits behind a full, stalled output
  assign oload    = !out_valid_r || out_ready;
  assign adv      = oload || !fin_valid;
  assign in_ready = adv;

  ctst_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (adv),
    .in_valid          (in_valid),
    .incoming_x        (in_incoming_x),
    .incoming_y        (in_incoming_y),
    .incoming_z        (in_incoming_z),
    .outgoing_x        (in_outgoing_x),
    .outgoing_y        (in_outgoing_y),
    .outgoing_z        (in_outgoing_z),
    .normal_x          (in_normal_x),
    .normal_y          (in_normal_y),
    .normal_z          (in_normal_z),
    .half_cosine       (in_half_cosine),
    .roughness_squared (in_roughness_squared),
    .out_valid         (fr_valid),
    .res               (fr)
  );

  assign dqs_in     = '{den: fr.den, dd_zero: fr.dd_zero};
  assign g1_side_in = {fr.g1_neg, fr.g1_zero};
  assign g2_side_in = {fr.g2_neg, fr.g2_zero};

  ctst_div #(
    .D_W    (ctst_pkg::DD_W),
    .Q_W    (ctst_pkg::NUM_W),
    .SIDE_W ($bits(ctst_pkg::dq_side_t))
  ) u_div_dq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .rem_init  ('0),
    .num       (fr.dq_num),
    .den       (fr.dd),
    .side_in   (dqs_in),
    .out_valid (dq_valid),
    .quo       (dq_quo),
    .side_out  (dqs_out)
  );

  ctst_div #(
    .D_W    (ctst_pkg::GD_W),
    .Q_W    (ctst_pkg::NUM_W),
    .SIDE_W (2)
  ) u_div_g1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .rem_init  ('0),
    .num       ({{ctst_pkg::GN_PAD{1'b0}}, fr.nl, 16'd0}),
    .den       (fr.g1_den),
    .side_in   (g1_side_in),
    .out_valid (g1_valid),
    .quo       (g1_quo),
    .side_out  (g1_side_out)
  );

  ctst_div #(
    .D_W    (ctst_pkg::GD_W),
    .Q_W    (ctst_pkg::NUM_W),
    .SIDE_W (2)
  ) u_div_g2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .rem_init  ('0),
    .num       ({{ctst_pkg::GN_PAD{1'b0}}, fr.nv, 16'd0}),
    .den       (fr.g2_den),
    .side_in   (g2_side_in),
    .out_valid (g2_valid),
    .quo       (g2_quo),
    .side_out  (g2_side_out)
  );

  // a zero geometry denominator makes that factor zero
  assign g1_mag = g1_side_out[0] ? '0 : g1_quo[ctst_pkg::GQ_W-1:0];
  assign g2_mag = g2_side_out[0] ? '0 : g2_quo[ctst_pkg::GQ_W-1:0];
  assign gs_in  = '{dq: dq_quo, den: dqs_out.den, dd_zero: dqs_out.dd_zero,
                    neg: g1_side_out[1] ^ g2_side_out[1]};

  ctst_mulsat #(
    .A_W    (ctst_pkg::GQ_W),
    .B_W    (ctst_pkg::GQ_W),
    .SIDE_W ($bits(ctst_pkg::g_side_t))
  ) u_mul_g (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (dq_valid & g1_valid & g2_valid),
    .a         (g1_mag),
    .b         (g2_mag),
    .side_in   (gs_in),
    .out_valid (gm_valid),
    .mag       (gm_mag),
    .side_out  (gs_out)
  );

  assign dgs_in = '{den: gs_out.den, dd_zero: gs_out.dd_zero, neg: gs_out.neg};

  ctst_mulsat #(
    .A_W    (ctst_pkg::NUM_W),
    .B_W    (ctst_pkg::MAG_W),
    .SIDE_W ($bits(ctst_pkg::dg_side_t))
  ) u_mul_dg (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (gm_valid),
    .a         (gs_out.dq),
    .b         (gm_mag),
    .side_in   (dgs_in),
    .out_valid (dgm_valid),
    .mag       (dg_mag),
    .side_out  (dgs_out)
  );

  always_comb begin
    priority if (dgs_out.dd_zero) begin
      kind_nxt = RES_SAT;
    end else if (dgs_out.neg || dg_mag == '0) begin
      kind_nxt = RES_ZERO;
    end else if (dg_mag >= ctst_pkg::MAG_W'(dgs_out.den)) begin
      kind_nxt = RES_SAT;
    end else begin
      kind_nxt = RES_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_valid_r <= 1'b0;
    end else if (adv) begin
      cls_valid_r <= dgm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_kind_r <= kind_nxt;
      cls_x_r    <= dg_mag[ctst_pkg::DEN_W-1:0];
      cls_den_r  <= dgs_out.den;
    end
  end

  // floor(x * 2^32 / den) with x below den
  ctst_div #(
    .D_W    (ctst_pkg::DEN_W),
    .Q_W    (ctst_pkg::OUT_W),
    .SIDE_W (2)
  ) u_div_fin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (cls_valid_r),
    .rem_init  (cls_x_r),
    .num       ('0),
    .den       (cls_den_r),
    .side_in   (cls_kind_r),
    .out_valid (fin_valid),
    .quo       (fin_quo),
    .side_out  (fin_side)
  );

  always_comb begin
    unique case (res_kind_t'(fin_side))
      RES_DIV: begin
        value_nxt = fin_quo;
        sat_nxt   = 1'b0;
      end
      RES_ZERO: begin
        value_nxt = '0;
        sat_nxt   = 1'b0;
      end
      RES_SAT: begin
        value_nxt = '1;
        sat_nxt   = 1'b1;
      end
      default: begin
        value_nxt = '0;
        sat_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (oload) begin
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (oload && fin_valid) begin
      value_r <= value_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_specular_value = value_r;
  assign out_saturated      = sat_r;

  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_specular_value == '1)
    else $error("saturated result is not all ones");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> fin_valid && out_valid_r)
    else $error("pipeline stalled without a waiting result");

  a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cls_valid_r && cls_kind_r == RES_DIV |-> cls_x_r < cls_den_r)
    else $error("final division would overflow the quotient");

  a_mag_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    dgm_valid |-> dg_mag <= ctst_pkg::MAG_LIMIT)
    else $error("product magnitude above clamp limit");

endmodule
`default_nettype wire
